// File: hdl/lds_pkg.sv
`default_nettype none

package lds_pkg;

    // fixed-point format of the baseline
    localparam int FRAC_BITS = 8;
    localparam int LUX_W     = 16;
    localparam int BASE_W    = LUX_W + FRAC_BITS;
    // drop numerator holds (baseline - reading) * 100
    localparam int NUM_W     = BASE_W + 7;
    localparam int PCT_W     = 7;
    localparam int DIV_W     = 4;
    localparam int CNT_W     = 4;
    // quotient bits produced by the serial divider
    localparam int QSTEPS    = PCT_W;
    localparam int STEP_W    = $clog2(QSTEPS);

    // configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_DIVISOR   = 2'd1,
        REG_CONFIRM   = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    localparam logic [PCT_W-1:0] THRESHOLD_RST = PCT_W'(30);
    localparam logic [DIV_W-1:0] DIVISOR_RST   = DIV_W'(2);
    localparam logic [CNT_W-1:0] CONFIRM_RST   = CNT_W'(3);
    localparam logic [PCT_W-1:0] PCT_MAX       = PCT_W'(100);

    // edge codes of a result
    typedef enum logic [1:0] {
        EDGE_NONE    = 2'd0,
        EDGE_ENTER   = 2'd1,
        EDGE_RELEASE = 2'd2,
        EDGE_UNUSED  = 2'd3
    } t_edge;

endpackage

`default_nettype wire

// File: hdl/light_drop_shade_detector.sv
// a failed or seeding reading goes from S_IDLE straight to S_RESULT, others first pass
//   S_BASE, S_SETUP, S_DIV and S_DECIDE; a new reading is taken only in S_IDLE, once the
//   last result is in the output register (S_RESULT waits while that is full and not
//   taken); the 7-step bit-serial divider forms the drop percent and release threshold
// reset: synchronous active-low i_rst_n clears state, baseline and counters and loads
//   register defaults (threshold 30, divisor 2, confirm count 3)
`default_nettype none

module light_drop_shade_detector (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input transaction
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [lds_pkg::LUX_W-1:0]     i_lux,
    input  wire logic                          i_read_failed,
    // result transaction
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_edge_res,
    output logic                               o_shaded,
    output logic [lds_pkg::PCT_W-1:0]          o_drop_percent,
    output logic                               o_sensor_fault,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lds_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [lds_pkg::PDATA_W-1:0]   pwdata,
    output logic [lds_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SETUP,
        S_DIV,
        S_DECIDE,
        S_RESULT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [lds_pkg::PCT_W-1:0]  r_threshold;
    logic [lds_pkg::DIV_W-1:0]  r_divisor;
    logic [lds_pkg::CNT_W-1:0]  r_confirm;

    // detector state
    logic                        r_shaded;
    logic                        r_base_valid;
    logic [lds_pkg::BASE_W-1:0]  r_base;
    logic [lds_pkg::CNT_W-1:0]   r_conf_cnt;
    logic [lds_pkg::PCT_W-1:0]   r_last_drop;

    // captured reading
    logic [lds_pkg::BASE_W-1:0]  r_xs;

    // serial divider
    logic [lds_pkg::NUM_W-1:0]   r_rem;
    logic [lds_pkg::NUM_W-1:0]   r_dvs;
    logic [lds_pkg::PCT_W-1:0]   r_quot;
    logic [lds_pkg::PCT_W-1:0]   r_trem;
    logic [lds_pkg::PCT_W+lds_pkg::DIV_W-1:0] r_tden;
    logic [lds_pkg::PCT_W-1:0]   r_rel;
    logic [lds_pkg::STEP_W-1:0]  r_step;

    // pending result
    lds_pkg::t_edge              r_res_edge;
    logic                        r_res_fault;

    // output register
    logic                        r_o_valid;
    lds_pkg::t_edge              r_o_edge;
    logic                        r_o_shaded;
    logic [lds_pkg::PCT_W-1:0]   r_o_drop;
    logic                        r_o_fault;

    logic                        w_in_xfer;
    logic                        w_out_free;
    logic                        w_cfg_wr;
    lds_pkg::t_reg_idx           w_idx;
    logic [lds_pkg::BASE_W-1:0]  w_lux_scaled;
    logic [lds_pkg::BASE_W+4:0]  w_ema_sum;
    logic [lds_pkg::BASE_W-1:0]  w_base_next;
    logic [lds_pkg::BASE_W-1:0]  w_diff;
    logic [lds_pkg::NUM_W-1:0]   w_num;
    logic                        w_qbit;
    logic                        w_tbit;
    logic [lds_pkg::DIV_W-1:0]   w_div_eff;
    logic [lds_pkg::PCT_W-1:0]   w_drop;
    logic                        w_hit;
    logic [lds_pkg::CNT_W-1:0]   w_cnt_inc;
    logic                        w_toggle;

    // handshakes
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_idx      = lds_pkg::t_reg_idx'(paddr[lds_pkg::REG_IDX_W+1:2]);

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_edge_res     = r_o_edge;
    assign o_shaded       = r_o_shaded;
    assign o_drop_percent = r_o_drop;
    assign o_sensor_fault = r_o_fault;
    assign pready         = 1'b1;

    // register read-back
    always_comb begin
        prdata = '0;
        unique case (w_idx)
            lds_pkg::REG_THRESHOLD: prdata = lds_pkg::PDATA_W'(r_threshold);
            lds_pkg::REG_DIVISOR:   prdata = lds_pkg::PDATA_W'(r_divisor);
            lds_pkg::REG_CONFIRM:   prdata = lds_pkg::PDATA_W'(r_confirm);
            default:                prdata = '0;
        endcase
    end

    // baseline update: jump up to brighter readings, else (15*b + x) / 16
    assign w_lux_scaled = {i_lux, {lds_pkg::FRAC_BITS{1'b0}}};
    assign w_ema_sum    = {1'b0, r_base, 4'b0000} - (lds_pkg::BASE_W+5)'(r_base)
                          + (lds_pkg::BASE_W+5)'(r_xs);
    assign w_base_next  = (r_xs >= r_base) ? r_xs : w_ema_sum[lds_pkg::BASE_W+3:4];

    // drop numerator (b - x) * 100 as a sum of shifts
    assign w_diff = r_base - r_xs;
    assign w_num  = (lds_pkg::NUM_W'(w_diff) << 6) + (lds_pkg::NUM_W'(w_diff) << 5)
                    + (lds_pkg::NUM_W'(w_diff) << 2);

    // one quotient bit per cycle for the drop and the release threshold
    assign w_qbit    = (r_rem >= r_dvs);
    assign w_tbit    = ((lds_pkg::PCT_W+lds_pkg::DIV_W)'(r_trem) >= r_tden);
    assign w_div_eff = (r_divisor == '0) ? lds_pkg::DIV_W'(1) : r_divisor;

    // hysteresis decision
    assign w_drop    = (r_quot > lds_pkg::PCT_MAX) ? lds_pkg::PCT_MAX : r_quot;
    assign w_hit     = r_shaded ? (w_drop < r_rel) : (w_drop >= r_threshold);
    assign w_cnt_inc = r_conf_cnt + lds_pkg::CNT_W'(1);
    assign w_toggle  = w_hit && (w_cnt_inc >= r_confirm);

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_threshold  <= lds_pkg::THRESHOLD_RST;
            r_divisor    <= lds_pkg::DIVISOR_RST;
            r_confirm    <= lds_pkg::CONFIRM_RST;
            r_shaded     <= 1'b0;
            r_base_valid <= 1'b0;
            r_base       <= '0;
            r_conf_cnt   <= '0;
            r_last_drop  <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            // configuration writes
            if (w_cfg_wr) begin
                unique case (w_idx)
                    lds_pkg::REG_THRESHOLD: r_threshold <= pwdata[lds_pkg::PCT_W-1:0];
                    lds_pkg::REG_DIVISOR:   r_divisor   <= pwdata[lds_pkg::DIV_W-1:0];
                    lds_pkg::REG_CONFIRM:   r_confirm   <= pwdata[lds_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end

            // result taken and no new one loaded this cycle
            if (r_o_valid && i_ready && (r_state != S_RESULT)) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_xs        <= w_lux_scaled;
                        r_res_edge  <= lds_pkg::EDGE_NONE;
                        r_res_fault <= i_read_failed;
                        if (i_read_failed) begin
                            r_state <= S_RESULT;
                        end else if (!r_base_valid) begin
                            // seeding reading loads the baseline
                            r_base       <= w_lux_scaled;
                            r_base_valid <= 1'b1;
                            r_state      <= S_RESULT;
                        end else begin
                            r_state <= S_BASE;
                        end
                    end
                end
                S_BASE: begin
                    // baseline frozen while shaded
                    if (!r_shaded) begin
                        r_base <= w_base_next;
                    end
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    if (r_xs >= r_base) begin
                        // no drop: divisor beyond any remainder gives a zero quotient
                        r_rem <= '0;
                        r_dvs <= '1;
                    end else begin
                        r_rem <= w_num;
                        r_dvs <= lds_pkg::NUM_W'(r_base) << (lds_pkg::QSTEPS-1);
                    end
                    r_trem  <= r_threshold;
                    r_tden  <= (lds_pkg::PCT_W+lds_pkg::DIV_W)'(w_div_eff)
                               << (lds_pkg::QSTEPS-1);
                    r_quot  <= '0;
                    r_rel   <= '0;
                    r_step  <= lds_pkg::STEP_W'(lds_pkg::QSTEPS-1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_qbit) begin
                        r_rem <= r_rem - r_dvs;
                    end
                    if (w_tbit) begin
                        r_trem <= r_trem - r_tden[lds_pkg::PCT_W-1:0];
                    end
                    r_dvs  <= r_dvs >> 1;
                    r_tden <= r_tden >> 1;
                    r_quot <= {r_quot[lds_pkg::PCT_W-2:0], w_qbit};
                    r_rel  <= {r_rel[lds_pkg::PCT_W-2:0], w_tbit};
                    if (r_step == '0) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_step <= r_step - lds_pkg::STEP_W'(1);
                    end
                end
                S_DECIDE: begin
                    r_last_drop <= w_drop;
                    if (w_toggle) begin
                        r_conf_cnt <= '0;
                        r_shaded   <= !r_shaded;
                        r_res_edge <= r_shaded ? lds_pkg::EDGE_RELEASE : lds_pkg::EDGE_ENTER;
                    end else if (w_hit) begin
                        r_conf_cnt <= w_cnt_inc;
                    end else begin
                        r_conf_cnt <= '0;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_edge   <= r_res_edge;
                        r_o_shaded <= r_shaded;
                        r_o_drop   <= r_last_drop;
                        r_o_fault  <= r_res_fault;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
